// ===== src/cbpm_pkg.sv =====
// Shared constants for the clock buffer pool manager.
package cbpm_pkg;

  localparam int unsigned NumFramesDef = 32;
  localparam int unsigned PinBitsDef   = 8;

  localparam int unsigned FrameW  = 5;
  localparam int unsigned FileW   = 16;
  localparam int unsigned PageW   = 32;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned StatusW = 3;

  localparam logic [CmdW-1:0] CmdRead    = 3'd0;
  localparam logic [CmdW-1:0] CmdUnpin   = 3'd1;
  localparam logic [CmdW-1:0] CmdAlloc   = 3'd2;
  localparam logic [CmdW-1:0] CmdDispose = 3'd3;
  localparam logic [CmdW-1:0] CmdFlush   = 3'd4;

  localparam logic [StatusW-1:0] StOk        = 3'd0;
  localparam logic [StatusW-1:0] StAllPinned = 3'd1;
  localparam logic [StatusW-1:0] StNotPinned = 3'd2;
  localparam logic [StatusW-1:0] StPinFlush  = 3'd3;
  localparam logic [StatusW-1:0] StPinOvf    = 3'd4;

  localparam logic KindFinal     = 1'b0;
  localparam logic KindWriteback = 1'b1;

endpackage

// ===== src/clock_buffer_pool_manager_core.sv =====
// Top level of the clock buffer pool manager: command sequencer over the frame descriptor RAM.
//
//  channel  | dir | tuser      | tdata                                  | tlast
//  s_axis   | in  | cmd        | file_id, page_no, mark_dirty           | -
//  m_axis   | out | kind       | frame, out_file_id, out_page_no, hit,  | last
//           |     |            | status                                 |
//
// One command at a time. Take the command, then for each frame visited read the RAM and then
// evaluate and write back, then send the final word.
// A lookup walks up to NUM_FRAMES frames, a clock sweep up to 2*NUM_FRAMES, a flush NUM_FRAMES.
// Valid bits sit in flip-flops and are cleared by reset, so no clearing pass is needed.
// A stalled output holds the sequencer.
module clock_buffer_pool_manager_core #(
  parameter int unsigned NUM_FRAMES = cbpm_pkg::NumFramesDef,
  parameter int unsigned PIN_BITS   = cbpm_pkg::PinBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // file_id[15:0], page_no[47:16], mark_dirty[48]
  input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // frame[4:0], out_file_id[20:5], out_page_no[52:21],
                                     // hit[53], status[56:54]
  output logic        m_axis_tuser,  // kind
  output logic        m_axis_tlast   // last
);

  localparam int unsigned FW  = $clog2(NUM_FRAMES);
  localparam int unsigned CW  = $clog2(NUM_FRAMES + 1);
  localparam int unsigned DW  = 2 + PIN_BITS + cbpm_pkg::FileW + cbpm_pkg::PageW;
  localparam logic [FW-1:0] LastIdx = FW'(NUM_FRAMES - 1);
  localparam logic [CW-1:0] AllPinned = CW'(NUM_FRAMES);
  localparam logic [PIN_BITS-1:0] PinMax = '1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LK_RD = 3'd1;
  localparam logic [2:0] S_LK_EV = 3'd2;
  localparam logic [2:0] S_SW_RD = 3'd3;
  localparam logic [2:0] S_SW_EV = 3'd4;
  localparam logic [2:0] S_FL_RD = 3'd5;
  localparam logic [2:0] S_FL_EV = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_q, state_d;
  logic [NUM_FRAMES-1:0] vld_q, vld_d;
  logic [FW-1:0] idx_q, idx_d, hand_q, hand_d, hand_nx;
  logic [CW-1:0] pcnt_q, pcnt_d;
  logic [cbpm_pkg::CmdW-1:0] cmd_q, cmd_d;
  logic [cbpm_pkg::FileW-1:0] file_q, file_d;
  logic [cbpm_pkg::PageW-1:0] page_q, page_d;
  logic mark_q, mark_d;
  logic [FW-1:0] rfrm_q, rfrm_d;
  logic [cbpm_pkg::PageW-1:0] rpage_q, rpage_d;
  logic rhit_q, rhit_d;
  logic [cbpm_pkg::StatusW-1:0] rst_q, rst_d;

  logic o_vld_q, o_vld_d, o_kind_q, o_kind_d, o_last_q, o_last_d, o_hit_q, o_hit_d;
  logic [FW-1:0] o_frm_q, o_frm_d;
  logic [cbpm_pkg::FileW-1:0] o_file_q, o_file_d;
  logic [cbpm_pkg::PageW-1:0] o_page_q, o_page_d;
  logic [cbpm_pkg::StatusW-1:0] o_st_q, o_st_d;
  logic out_free;

  logic ram_we;
  logic [FW-1:0] ram_waddr, ram_raddr, cur;
  logic [DW-1:0] ram_wdata, ram_rdata, fill_data;
  logic v, d_dirty, d_ref;
  logic [PIN_BITS-1:0] d_pin;
  logic [cbpm_pkg::FileW-1:0] d_file;
  logic [cbpm_pkg::PageW-1:0] d_page;
  logic tag_hit;
  logic [FW+4:0] frm_ext;

  cbpm_ram #(.Width(DW), .Depth(NUM_FRAMES)) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cur      = (state_q == S_SW_EV) ? hand_q : idx_q;
  assign v        = vld_q[cur];
  assign d_dirty  = ram_rdata[0] & v;
  assign d_ref    = ram_rdata[1] & v;
  assign d_pin    = ram_rdata[2 +: PIN_BITS] & {PIN_BITS{v}};
  assign d_file   = ram_rdata[2+PIN_BITS +: cbpm_pkg::FileW];
  assign d_page   = ram_rdata[2+PIN_BITS+cbpm_pkg::FileW +: cbpm_pkg::PageW];
  assign tag_hit  = v && (d_file == file_q) && (d_page == page_q);
  assign fill_data = {page_q, file_q, PIN_BITS'(1), 1'b1, 1'b0};
  assign hand_nx  = (hand_q == LastIdx) ? '0 : hand_q + 1'b1;
  assign out_free = !o_vld_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign frm_ext       = {5'b0, o_frm_q};
  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {7'b0, o_st_q, o_hit_q, o_page_q, o_file_q, frm_ext[4:0]};

  always_comb begin
    state_d = state_q; vld_d = vld_q; idx_d = idx_q; hand_d = hand_q; pcnt_d = pcnt_q;
    cmd_d = cmd_q; file_d = file_q; page_d = page_q; mark_d = mark_q;
    rfrm_d = rfrm_q; rpage_d = rpage_q; rhit_d = rhit_q; rst_d = rst_q;
    o_vld_d = o_vld_q && !m_axis_tready;
    o_kind_d = o_kind_q; o_last_d = o_last_q; o_hit_d = o_hit_q; o_frm_d = o_frm_q;
    o_file_d = o_file_q; o_page_d = o_page_q; o_st_d = o_st_q;
    ram_we = 1'b0; ram_waddr = cur; ram_wdata = ram_rdata; ram_raddr = cur;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d  = s_axis_tuser;
          file_d = s_axis_tdata[15:0];
          page_d = s_axis_tdata[47:16];
          mark_d = s_axis_tdata[48];
          idx_d  = '0;
          pcnt_d = '0;
          rfrm_d = '0; rpage_d = s_axis_tdata[47:16]; rhit_d = 1'b0;
          rst_d  = cbpm_pkg::StOk;
          priority if (s_axis_tuser == cbpm_pkg::CmdRead || s_axis_tuser == cbpm_pkg::CmdUnpin
                       || s_axis_tuser == cbpm_pkg::CmdDispose) begin
            state_d = S_LK_RD;
          end else if (s_axis_tuser == cbpm_pkg::CmdAlloc) begin
            state_d = S_SW_RD;
          end else if (s_axis_tuser == cbpm_pkg::CmdFlush) begin
            state_d = S_FL_RD;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_LK_RD: begin
        ram_raddr = idx_q;
        state_d = S_LK_EV;
      end
      S_LK_EV: begin
        if (tag_hit) begin
          rfrm_d = idx_q; rhit_d = 1'b1;
          state_d = S_FIN;
          ram_waddr = idx_q;
          if (cmd_q == cbpm_pkg::CmdRead) begin
            if (d_pin == PinMax) begin
              rst_d = cbpm_pkg::StPinOvf;
            end else begin
              ram_we = 1'b1;
              ram_wdata = {d_page, d_file, d_pin + 1'b1, 1'b1, d_dirty};
            end
          end else if (cmd_q == cbpm_pkg::CmdUnpin) begin
            if (d_pin == '0) begin
              rst_d = cbpm_pkg::StNotPinned;
            end else begin
              ram_we = 1'b1;
              ram_wdata = {d_page, d_file, d_pin - 1'b1, d_ref, d_dirty | mark_q};
            end
          end else begin
            vld_d[idx_q] = 1'b0;
          end
        end else if (idx_q == LastIdx) begin
          state_d = (cmd_q == cbpm_pkg::CmdRead) ? S_SW_RD : S_FIN;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = S_LK_RD;
        end
      end
      S_SW_RD: begin
        ram_raddr = hand_nx;
        hand_d = hand_nx;
        state_d = S_SW_EV;
      end
      S_SW_EV: begin
        ram_waddr = hand_q;
        if (v && d_ref) begin
          ram_we = 1'b1;
          ram_wdata = {d_page, d_file, d_pin, 1'b0, d_dirty};
          state_d = S_SW_RD;
        end else if (v && d_pin != '0) begin
          pcnt_d = pcnt_q + 1'b1;
          if (pcnt_q + 1'b1 == AllPinned) begin
            rst_d = cbpm_pkg::StAllPinned;
            state_d = S_FIN;
          end else begin
            state_d = S_SW_RD;
          end
        end else if (!d_dirty || out_free) begin
          if (d_dirty) begin
            o_vld_d = 1'b1; o_kind_d = cbpm_pkg::KindWriteback; o_last_d = 1'b0;
            o_hit_d = 1'b0; o_frm_d = hand_q; o_file_d = d_file; o_page_d = d_page;
            o_st_d = cbpm_pkg::StOk;
          end
          ram_we = 1'b1;
          ram_wdata = fill_data;
          vld_d[hand_q] = 1'b1;
          rfrm_d = hand_q;
          state_d = S_FIN;
        end
      end
      S_FL_RD: begin
        ram_raddr = idx_q;
        state_d = S_FL_EV;
      end
      S_FL_EV: begin
        if (v && d_file == file_q && d_pin != '0) begin
          rfrm_d = idx_q; rpage_d = d_page; rst_d = cbpm_pkg::StPinFlush;
          state_d = S_FIN;
        end else if (!(v && d_file == file_q && d_dirty) || out_free) begin
          if (v && d_file == file_q) begin
            vld_d[idx_q] = 1'b0;
            if (d_dirty) begin
              o_vld_d = 1'b1; o_kind_d = cbpm_pkg::KindWriteback; o_last_d = 1'b0;
              o_hit_d = 1'b0; o_frm_d = idx_q; o_file_d = d_file; o_page_d = d_page;
              o_st_d = cbpm_pkg::StOk;
            end
          end
          if (idx_q == LastIdx) begin
            rpage_d = '0;
            state_d = S_FIN;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = S_FL_RD;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          o_vld_d = 1'b1; o_kind_d = cbpm_pkg::KindFinal; o_last_d = 1'b1;
          o_hit_d = rhit_q; o_frm_d = rfrm_q; o_file_d = file_q; o_page_d = rpage_q;
          o_st_d = rst_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= '0;
      hand_q  <= LastIdx;
      o_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      hand_q  <= hand_d;
      o_vld_q <= o_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; pcnt_q <= pcnt_d;
    cmd_q <= cmd_d; file_q <= file_d; page_q <= page_d; mark_q <= mark_d;
    rfrm_q <= rfrm_d; rpage_q <= rpage_d; rhit_q <= rhit_d; rst_q <= rst_d;
    o_kind_q <= o_kind_d; o_last_q <= o_last_d; o_hit_q <= o_hit_d; o_frm_q <= o_frm_d;
    o_file_q <= o_file_d; o_page_q <= o_page_d; o_st_q <= o_st_d;
  end

endmodule

// ===== src/cbpm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cbpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
